// ----- rtl/sws_pkg.sv -----
// Package for the stack with search: item types, operation and status codes.
// No dependencies.
package sws_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] top_value;
    logic        top_valid;
    logic [6:0]  entries_held;
    logic        found;
    logic [5:0]  found_position;
    logic [1:0]  status;
  } out_item_t;

endpackage

// ----- rtl/sws_ram.sv -----
// Entry store of the stack: one write port, one read port, registered read data.
// No dependencies.
module sws_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/stack_with_search.sv -----
// Top level of the stack with search: sequencer, top-of-stack register, result register.
// Depends on sws_pkg and sws_ram.
//
//   channel | signals                     | payload
//   in      | in_valid / in_ready         | in_item  (opcode, value)
//   out     | out_valid / out_ready       | out_item (top, count, search result, status)
//
// Push and status go from accept to S_DONE and then into the result register; a
// pop that removes an entry passes through S_POP first, since it waits on the
// store's read port. A search reads one entry per cycle from the top down.
// Reset empties the stack at once (fill count only). A waiting result holds the
// next item's completion, not its acceptance.
module stack_with_search
  import sws_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state;
  logic [CW-1:0]         fill;
  logic [DATA_WIDTH-1:0] top;
  logic [DATA_WIDTH-1:0] key;
  logic [AW-1:0]         cmp_idx;
  logic                  found;
  logic [AW-1:0]         pos;
  logic [1:0]            status;

  logic                  accept;
  logic                  res_load;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  wr_en;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);
  assign in_val   = DATA_WIDTH'(in_item.value);
  assign wr_en    = accept && (in_item.opcode == OP_PUSH) && (fill != CW'(DEPTH));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cmp_idx - AW'(1);
    unique case (state)
      S_IDLE: begin
        if (accept && in_item.opcode == OP_POP && fill > CW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(fill - CW'(2));
        end else if (accept && in_item.opcode == OP_SEARCH && fill != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(fill - CW'(1));
        end
      end
      S_SRCH: begin
        rd_en = (rd_data != key) && (cmp_idx != '0);
      end
      S_POP, S_DONE: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  sws_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(fill)),
    .wr_data (in_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            found  <= 1'b0;
            pos    <= '0;
            status <= ST_OK;
            key    <= in_val;
            state  <= S_DONE;
            case (in_item.opcode)
              OP_PUSH: begin
                if (fill == CW'(DEPTH)) begin
                  status <= ST_PUSH_FULL;
                end else begin
                  fill <= fill + CW'(1);
                  top  <= in_val;
                end
              end
              OP_POP: begin
                if (fill == '0) begin
                  status <= ST_POP_EMPTY;
                end else begin
                  fill  <= fill - CW'(1);
                  state <= S_POP;
                end
              end
              OP_SEARCH: begin
                if (fill != '0) begin
                  cmp_idx <= AW'(fill - CW'(1));
                  state   <= S_SRCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          top   <= rd_data;
          state <= S_DONE;
        end
        S_SRCH: begin
          if (rd_data == key) begin
            found <= 1'b1;
            pos   <= cmp_idx;
            state <= S_DONE;
          end else if (cmp_idx == '0) begin
            state <= S_DONE;
          end else begin
            cmp_idx <= cmp_idx - AW'(1);
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item.top_value      <= (fill != '0) ? 32'(top) : '0;
      out_item.top_valid      <= (fill != '0);
      out_item.entries_held   <= 7'(fill);
      out_item.found          <= found;
      out_item.found_position <= 6'(pos);
      out_item.status         <= status;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item did not start an operation");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid && state == S_IDLE)
    else $error("finished operation did not present a result");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |-> fill != '0)
    else $error("search scan on empty stack");

  a_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> accept && fill < CW'(DEPTH))
    else $error("store write outside an accepted push");

endmodule
